[hdl/twa_pkg.sv]
// Shared types and constants for the timed window average block.
// No dependencies.
`default_nettype none
package twa_pkg;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned TIME_W = 32;

    typedef enum logic {
        CMD_MEASURE = 1'b0,
        CMD_CLEAR   = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_WINDOW_MS = 1'b0,
        REG_JUMP      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cmd_t               command;
        logic [VAL_W-1:0]   sample_value;
        logic [TIME_W-1:0]  time_ms;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_DIVIDE,
        ST_DONE
    } back_state_t;
endpackage
`default_nettype wire

[hdl/twa_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module twa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[hdl/twa_front.sv]
// Front end: accepts items into a two-entry queue toward the back end.
// Depends on twa_pkg.
`default_nettype none
module twa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire twa_pkg::job_t in_job,
    output logic               job_valid,
    output twa_pkg::job_t      job,
    input  wire logic          job_take
);
    import twa_pkg::*;

    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= ~wr_reg;
            end
            if (job_take && job_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, job_take && job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_reg[wr_reg] <= in_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (rd_reg == wr_reg))
        else $error("empty queue pointers differ");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (rd_reg == wr_reg))
        else $error("full queue pointers differ");
endmodule
`default_nettype wire

[hdl/twa_back.sv]
// Back end: clear and jump reset, expiry, eviction, append and serial mean of the window.
// Depends on twa_pkg and twa_ram.
`default_nettype none
module twa_back #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire twa_pkg::job_t job,
    output logic               job_take,
    input  wire logic [31:0]   window_ms,
    input  wire logic [31:0]   jump_threshold,
    output logic               res_valid,
    input  wire logic          res_take,
    output logic [31:0]        average,
    output logic [$clog2(DEPTH+1)-1:0] sample_count,
    output logic               was_reset,
    output logic               overflowed
);
    import twa_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam int unsigned PW = CW + 1;
    localparam int unsigned SW = VAL_W + CW;
    localparam int unsigned QW = SW;
    localparam int unsigned KW = $clog2(QW+1);

    back_state_t st_reg, st_next;
    job_t        job_reg;
    logic [AW-1:0] old_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [31:0]   avg_reg;
    logic          rflag_reg, oflag_reg;
    logic          res_reg;
    logic [SW-1:0] num_reg;
    logic [CW:0]   rem_reg;
    logic [KW-1:0] bit_reg;

    logic [31:0] val_rd, stamp_rd;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] slot_sum;
    logic [AW-1:0] old_inc;
    logic [31:0] diff;
    logic [31:0] age;
    logic [CW:0] rem_sh;

    assign wr_en    = (st_reg == ST_WRITE);
    assign slot_sum = PW'(old_reg) + PW'(cnt_reg);
    assign wr_addr  = (slot_sum >= PW'(DEPTH)) ? AW'(slot_sum - PW'(DEPTH)) : AW'(slot_sum);
    assign old_inc  = (old_reg == AW'(DEPTH-1)) ? '0 : old_reg + 1'b1;

    twa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(job_reg.sample_value),
        .rd_addr(old_reg), .rd_data(val_rd));
    twa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stamp (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(job_reg.time_ms),
        .rd_addr(old_reg), .rd_data(stamp_rd));

    assign diff   = (avg_reg > job.sample_value) ? avg_reg - job.sample_value
                                                 : job.sample_value - avg_reg;
    assign age    = job_reg.time_ms - stamp_rd;
    assign rem_sh = {rem_reg[CW-1:0], num_reg[QW-1]};

    assign job_take     = (st_reg == ST_IDLE) && !res_reg && job_valid;
    assign res_valid    = res_reg;
    assign average      = avg_reg;
    assign sample_count = cnt_reg;
    assign was_reset    = rflag_reg;
    assign overflowed   = oflag_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (job_take) st_next = (job.command == CMD_CLEAR) ? ST_DONE : ST_READ;
            ST_READ:   st_next = ST_CHECK;
            ST_CHECK:  if (cnt_reg == '0 || age <= window_ms) st_next = ST_WRITE;
                       else st_next = ST_READ;
            ST_WRITE:  st_next = ST_DIVIDE;
            ST_DIVIDE: if (bit_reg == KW'(QW-1)) st_next = ST_DONE;
            ST_DONE:   st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            old_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            avg_reg   <= '0;
            rflag_reg <= 1'b0;
            oflag_reg <= 1'b0;
            res_reg   <= 1'b0;
            num_reg   <= '0;
            rem_reg   <= '0;
            bit_reg   <= '0;
            job_reg   <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (res_reg && res_take)
            begin
                res_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        job_reg   <= job;
                        rflag_reg <= 1'b0;
                        oflag_reg <= 1'b0;
                        if (job.command == CMD_CLEAR ||
                            (jump_threshold != '0 && diff > jump_threshold))
                        begin
                            old_reg <= '0;
                            cnt_reg <= '0;
                            sum_reg <= '0;
                            avg_reg <= '0;
                            rflag_reg <= (job.command == CMD_MEASURE);
                        end
                    end
                end
                ST_READ: ;
                ST_CHECK:
                begin
                    if (cnt_reg != '0 && (age > window_ms || cnt_reg == CW'(DEPTH)))
                    begin
                        if (age <= window_ms)
                        begin
                            oflag_reg <= 1'b1;
                        end
                        sum_reg <= sum_reg - SW'(val_rd);
                        old_reg <= old_inc;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_WRITE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= sum_reg + SW'(job_reg.sample_value);
                    num_reg <= sum_reg + SW'(job_reg.sample_value) + SW'((cnt_reg + 1'b1) >> 1);
                    rem_reg <= '0;
                    bit_reg <= '0;
                end
                ST_DIVIDE:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (rem_sh >= {1'b0, cnt_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, cnt_reg};
                        num_reg <= {num_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[QW-2:0], 1'b0};
                    end
                end
                ST_DONE:
                begin
                    if (job_reg.command == CMD_MEASURE)
                    begin
                        avg_reg <= num_reg[31:0];
                    end
                    res_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("window count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DONE) |=> res_reg)
        else $error("result not posted");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> !res_reg)
        else $error("job taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_WRITE) |-> (cnt_reg < CW'(DEPTH)))
        else $error("append into full ring");
endmodule
`default_nettype wire

[hdl/timed_window_average.sv]
// Top level of the timed window average: config registers, front queue, back end.
// Depends on twa_pkg, twa_front, twa_back.
//
// Usage: an input item (command, sample_value, time_ms) is transferred when push
// is high and full is low. Each item yields one result (average, sample_count,
// was_reset, overflowed), shown while empty is low and transferred on pop.
// A two-entry queue buffers inputs while the back end works.
// A clear command goes from idle straight to done, which posts its result. A
// measure passes read and check (repeated for each expired sample), write, then
// divide, where the bit-serial divider computing the rounded mean works through
// SW = 41 quotient bits for the default depth, then done. Each expiry repeats
// read and check; a full ring evicts its oldest sample at no extra cost.
// Reset clears the window, the queue and the result; window_ms returns to
// 1000 and jump_threshold to 0. A held result stops the back end until popped;
// inputs keep queuing until full rises. Configuration writes take effect at once.
`default_nettype none
module timed_window_average #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [31:0] sample_value,
    input  wire logic [31:0] time_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      average,
    output logic [$clog2(DEPTH+1)-1:0] sample_count,
    output logic             was_reset,
    output logic             overflowed,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import twa_pkg::*;

    logic [31:0] window_reg, jump_reg;
    job_t in_job, job;
    logic job_valid, job_take, res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd1000;
            jump_reg   <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WINDOW_MS: window_reg <= cfg_data;
                REG_JUMP:      jump_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_job.command      = cmd_t'(command);
    assign in_job.sample_value = sample_value;
    assign in_job.time_ms      = time_ms;

    twa_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_job(in_job),
        .job_valid(job_valid), .job(job), .job_take(job_take));

    twa_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_take(job_take), .window_ms(window_reg), .jump_threshold(jump_reg),
        .res_valid(res_valid), .res_take(pop), .average(average),
        .sample_count(sample_count), .was_reset(was_reset), .overflowed(overflowed));

    assign empty = !res_valid;
endmodule
`default_nettype wire
